// ===== rtl/core/atle_pkg.sv =====
package atle_pkg;

	// Input item kinds (carried on s_tuser)
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_TICK    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// Result kinds (carried on m_tuser)
	localparam logic [1:0] RES_CONTENT = 2'd0;
	localparam logic [1:0] RES_LINE    = 2'd1;
	localparam logic [1:0] RES_TIMEOUT = 2'd2;

	// Characters the parser reacts to
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Register map, indexed by paddr[4:3]
	localparam int          ADDR_W          = 5;
	localparam logic [1:0]  REG_PREFIX_CHARS = 2'd0;
	localparam logic [1:0]  REG_PREFIX_LEN   = 2'd1;
	localparam logic [1:0]  REG_MAX_CONTENT  = 2'd2;
	localparam logic [1:0]  REG_TIMEOUT      = 2'd3;

	localparam logic [63:0] RST_PREFIX_CHARS = 64'h0000_0000_5354_4C51;
	localparam logic [3:0]  RST_PREFIX_LEN   = 4'd4;
	localparam logic [7:0]  RST_MAX_CONTENT  = 8'd255;
	localparam logic [7:0]  RST_TIMEOUT      = 8'd20;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_PREFIX  = 5'b00010,
		PH_SPACE   = 5'b00100,
		PH_CONTENT = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0][7:0] prefix_chars;
		logic [3:0]      prefix_len;
		logic [7:0]      max_content_len;
		logic [7:0]      timeout_seconds;
	} atle_cfg_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] content_length;
	} atle_result_t;

endpackage

// ===== rtl/core/at_response_line_extractor.sv =====
// Channel   | Dir | Signals                          | Contents
// ----------+-----+----------------------------------+-------------------------------------
// s_*       | in  | s_tvalid s_tready s_tdata s_tuser | tdata: byte_value; tuser: kind
// m_*       | out | m_tvalid m_tready m_tdata m_tuser | tdata: data_byte, content_length;
//           |     |                                  | tuser: result_kind
// APB       | in  | psel penable pwrite paddr pwdata | 4 regs at 0x00/0x08/0x10/0x18,
//           |     | prdata pready                    | 64-bit data, pready tied high
//
// One transaction per cycle sustained while the m_* side does not stall. An accepted
// item is captured in the input register, is parsed by the phase logic, and its
// result (if any) is captured in the output register, which drives m_*.
// Reset (arst_n low) clears the phase machine to search mode and reloads the
// register defaults. A stalled m_* side holds the output register; a full input
// register then holds too and s_tready drops until m_tready frees the slot.
module at_response_line_extractor #(
	parameter int PREFIX_MAX_CHARS = 8,
	parameter int PREFIX_BUFFER    = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// stream in
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] byte_value
	input  logic [1:0]                  s_tuser,   // [1:0] kind
	// stream out
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,   // [7:0] data_byte, [15:8] content_length
	output logic [1:0]                  m_tuser,   // [1:0] result_kind
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [atle_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);
	import atle_pkg::*;

	// configuration registers
	atle_cfg_t cfg_q;
	logic      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prefix_chars    <= RST_PREFIX_CHARS;
			cfg_q.prefix_len      <= RST_PREFIX_LEN;
			cfg_q.max_content_len <= RST_MAX_CONTENT;
			cfg_q.timeout_seconds <= RST_TIMEOUT;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_PREFIX_CHARS: cfg_q.prefix_chars    <= pwdata;
				REG_PREFIX_LEN:   cfg_q.prefix_len      <= pwdata[3:0];
				REG_MAX_CONTENT:  cfg_q.max_content_len <= pwdata[7:0];
				REG_TIMEOUT:      cfg_q.timeout_seconds <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_PREFIX_CHARS: prdata = cfg_q.prefix_chars;
			REG_PREFIX_LEN:   prdata = {60'd0, cfg_q.prefix_len};
			REG_MAX_CONTENT:  prdata = {56'd0, cfg_q.max_content_len};
			REG_TIMEOUT:      prdata = {56'd0, cfg_q.timeout_seconds};
			default:          prdata = '0;
		endcase
	end

	// input register
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;

	// output register
	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_data_q;
	logic [7:0] out_len_q;

	atle_result_t res;

	// the output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	atle_parser #(
		.PREFIX_MAX_CHARS(PREFIX_MAX_CHARS),
		.PREFIX_BUFFER   (PREFIX_BUFFER)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(advance),
		.item_kind (kind_s1),
		.item_byte (byte_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			out_kind_q <= res.kind;
			out_data_q <= res.data_byte;
			out_len_q  <= res.content_length;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_len_q, out_data_q};
	assign m_tuser  = out_kind_q;

endmodule

// ===== rtl/core/atle_parser.sv =====
module atle_parser #(
	parameter int PREFIX_MAX_CHARS = 8,
	parameter int PREFIX_BUFFER    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  atle_pkg::atle_cfg_t cfg,
	input  logic                item_valid,
	input  logic [1:0]          item_kind,
	input  logic [7:0]          item_byte,
	output atle_pkg::atle_result_t result
);
	import atle_pkg::*;

	localparam int CNT_W = $clog2(PREFIX_BUFFER);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] prefix_cnt_q, prefix_cnt_d;
	logic             mismatch_q, mismatch_d;
	logic [7:0]       content_cnt_q, content_cnt_d;
	logic [7:0]       ticks_q, ticks_d;

	logic [6:0] cnt_ext;
	logic [6:0] len_ext;
	logic [2:0] byte_idx;
	logic [8:0] ticks_next;

	assign cnt_ext    = 7'(prefix_cnt_q);
	assign len_ext    = 7'(cfg.prefix_len);
	assign byte_idx   = cnt_ext[2:0];
	assign ticks_next = {1'b0, ticks_q} + 9'd1;

	always_comb begin
		phase_d       = phase_q;
		prefix_cnt_d  = prefix_cnt_q;
		mismatch_d    = mismatch_q;
		content_cnt_d = content_cnt_q;
		ticks_d       = ticks_q;
		result        = '0;

		case (item_kind)
			KIND_RESTART: begin
				phase_d       = PH_IDLE;
				prefix_cnt_d  = '0;
				mismatch_d    = 1'b0;
				content_cnt_d = '0;
				ticks_d       = '0;
			end
			KIND_TICK: begin
				if (phase_q != PH_DONE) begin
					ticks_d = ticks_next[8] ? 8'hFF : ticks_next[7:0];
					if (ticks_next > {1'b0, cfg.timeout_seconds}) begin
						phase_d      = PH_DONE;
						result.valid = 1'b1;
						result.kind  = RES_TIMEOUT;
					end
				end
			end
			KIND_BYTE: begin
				unique case (phase_q)
					PH_IDLE: begin
						if (item_byte == CH_PLUS) begin
							phase_d      = PH_PREFIX;
							prefix_cnt_d = '0;
							mismatch_d   = 1'b0;
						end
					end
					PH_PREFIX: begin
						if (item_byte == CH_COLON) begin
							if (len_ext <= 7'(PREFIX_MAX_CHARS) && cnt_ext == len_ext
									&& !mismatch_q)
								phase_d = PH_SPACE;
							else
								phase_d = PH_IDLE;
						end else if (cnt_ext < 7'(PREFIX_BUFFER - 1)) begin
							if (cnt_ext < 7'(PREFIX_MAX_CHARS) && cnt_ext < 7'd8
									&& cfg.prefix_chars[byte_idx] != item_byte)
								mismatch_d = 1'b1;
							prefix_cnt_d = prefix_cnt_q + CNT_W'(1);
						end else begin
							phase_d = PH_IDLE;   // prefix too long for the buffer
						end
					end
					PH_SPACE: begin
						phase_d = (item_byte == CH_SPACE) ? PH_CONTENT : PH_IDLE;
					end
					PH_CONTENT: begin
						if (item_byte == CH_LF || item_byte == CH_CR) begin
							phase_d               = PH_DONE;
							result.valid          = 1'b1;
							result.kind           = RES_LINE;
							result.content_length = content_cnt_q;
						end else if (content_cnt_q < cfg.max_content_len) begin
							content_cnt_d    = content_cnt_q + 8'd1;
							result.valid     = 1'b1;
							result.kind      = RES_CONTENT;
							result.data_byte = item_byte;
						end
					end
					PH_DONE: begin
					end
					default: phase_d = PH_IDLE;
				endcase
			end
			default: begin
			end
		endcase

		if (!item_valid)
			result.valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			prefix_cnt_q  <= '0;
			mismatch_q    <= 1'b0;
			content_cnt_q <= '0;
			ticks_q       <= '0;
		end else if (item_valid) begin
			phase_q       <= phase_d;
			prefix_cnt_q  <= prefix_cnt_d;
			mismatch_q    <= mismatch_d;
			content_cnt_q <= content_cnt_d;
			ticks_q       <= ticks_d;
		end
	end

endmodule
